// File: rtl/core/stable_priority_queue_assert.svh
// Assertion macros shared by the priority queue RTL.
// Included by spq_engine.sv; the macros expect aclk and aresetn in scope.
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SPQ_ASSERT_NOW(label, ante, cons, msg)
`define SPQ_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: rtl/core/spq_pkg.sv
// Shared types and codes of the stable priority queue.
// No dependencies; used by spq_engine and stable_priority_queue.
package spq_pkg;

    // Default sizing.
    localparam int DEPTH_DEF      = 16;
    localparam int ITEM_BYTES_DEF = 4;

    // Operation selector codes.
    localparam logic [2:0] FN_PUSH  = 3'd0;
    localparam logic [2:0] FN_POP   = 3'd1;
    localparam logic [2:0] FN_PEEK  = 3'd2;
    localparam logic [2:0] FN_FIND  = 3'd3;
    localparam logic [2:0] FN_CLEAR = 3'd4;

    // Result status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // One request as captured from the input channel.
    typedef struct packed {
        logic [2:0]         func;
        logic [31:0]        item_data;
        logic signed [15:0] priority_req;
    } req_t;

    // One result as handed to the output register.
    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        data_out;
        logic               found;
        logic [4:0]         entry_total;
        logic signed [15:0] head_priority;
    } rsp_t;

    // Engine handshake status toward the top level.
    typedef struct packed {
        logic idle;
        logic done;
    } eng_stat_t;

endpackage

// File: rtl/core/spq_engine.sv
// Sequencer, entry memory and shared compare stage of the priority queue.
// Depends on spq_pkg and stable_priority_queue_assert.svh.
`include "stable_priority_queue_assert.svh"

module spq_engine #(
    parameter int DEPTH      = spq_pkg::DEPTH_DEF,
    parameter int ITEM_BYTES = spq_pkg::ITEM_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  spq_pkg::req_t        req,
    input  logic                 out_free,
    output spq_pkg::eng_stat_t   stat,
    output spq_pkg::rsp_t        rsp
);

    localparam int DW = (ITEM_BYTES * 8 >= 32) ? 32 : ITEM_BYTES * 8;
    localparam int EW = DW + 16;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_WNEW = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [2:0]    func_reg, func_next;
    logic [DW-1:0] word_reg, word_next;
    logic [15:0]   prio_reg, prio_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    status_reg, status_next;
    logic [DW-1:0] dout_reg, dout_next;
    logic          found_reg, found_next;
    logic [15:0]   head_prio_reg;
    logic [EW-1:0] rdata_reg;

    logic [EW-1:0] mem [DEPTH];

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic [AW-1:0] rd_addr;
    logic [15:0]   rd_prio;
    logic [DW-1:0] rd_data;
    logic          prio_lt;
    logic          data_eq;
    logic [CW-1:0] ptr_inc;
    logic          last;
    logic          done;

    // Push walks from the tail toward the head, so it reads one slot below the pointer.
    assign rd_addr = (func_reg == spq_pkg::FN_PUSH) ? ptr_reg - 1'b1 : ptr_reg;

    // Shared compare stage working on the registered read data.
    assign rd_prio = rdata_reg[EW-1:DW];
    assign rd_data = rdata_reg[DW-1:0];
    assign prio_lt = $signed(rd_prio) < $signed(prio_reg);
    assign data_eq = (rd_data == word_reg);
    assign ptr_inc = CW'(ptr_reg) + 1'b1;
    assign last    = (ptr_inc == count_reg);

    // Sequencer.
    always_comb begin
        state_next  = state_reg;
        func_next   = func_reg;
        word_next   = word_reg;
        prio_next   = prio_reg;
        ptr_next    = ptr_reg;
        count_next  = count_reg;
        status_next = status_reg;
        dout_next   = dout_reg;
        found_next  = found_reg;
        wr_en       = 1'b0;
        wr_addr     = ptr_reg;
        wr_data     = {prio_reg, word_reg};
        done        = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    func_next   = req.func;
                    word_next   = req.item_data[DW-1:0];
                    prio_next   = req.priority_req;
                    status_next = spq_pkg::STAT_OK;
                    dout_next   = '0;
                    found_next  = 1'b0;
                    ptr_next    = '0;
                    case (req.func)
                        spq_pkg::FN_PUSH: begin
                            if (count_reg == CW'(DEPTH)) begin
                                status_next = spq_pkg::STAT_FULL;
                                state_next  = S_DONE;
                            end else begin
                                ptr_next   = AW'(count_reg);
                                state_next = (count_reg == '0) ? S_WNEW : S_RD;
                            end
                        end
                        spq_pkg::FN_POP, spq_pkg::FN_PEEK: begin
                            if (count_reg == '0) begin
                                status_next = spq_pkg::STAT_EMPTY;
                                state_next  = S_DONE;
                            end else begin
                                state_next = S_RD;
                            end
                        end
                        spq_pkg::FN_FIND: begin
                            state_next = (count_reg == '0) ? S_DONE : S_RD;
                        end
                        spq_pkg::FN_CLEAR: begin
                            count_next = '0;
                            state_next = S_DONE;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_RD: begin
                state_next = S_CMP;
            end
            S_CMP: begin
                case (func_reg)
                    spq_pkg::FN_PUSH: begin
                        if (prio_lt) begin
                            // Lower priority entry moves one slot toward the tail.
                            wr_en    = 1'b1;
                            wr_data  = rdata_reg;
                            ptr_next = ptr_reg - 1'b1;
                            state_next = (ptr_reg == AW'(1)) ? S_WNEW : S_RD;
                        end else begin
                            // Equal or higher entry stays ahead, which keeps ties in arrival order.
                            wr_en      = 1'b1;
                            count_next = count_reg + 1'b1;
                            state_next = S_DONE;
                        end
                    end
                    spq_pkg::FN_POP: begin
                        if (ptr_reg == '0) begin
                            dout_next = rd_data;
                        end else begin
                            wr_en   = 1'b1;
                            wr_addr = ptr_reg - 1'b1;
                            wr_data = rdata_reg;
                        end
                        if (last) begin
                            count_next = count_reg - 1'b1;
                            state_next = S_DONE;
                        end else begin
                            ptr_next   = ptr_reg + 1'b1;
                            state_next = S_RD;
                        end
                    end
                    spq_pkg::FN_PEEK: begin
                        dout_next  = rd_data;
                        state_next = S_DONE;
                    end
                    spq_pkg::FN_FIND: begin
                        if (data_eq) begin
                            found_next = 1'b1;
                            state_next = S_DONE;
                        end else if (last) begin
                            state_next = S_DONE;
                        end else begin
                            ptr_next   = ptr_reg + 1'b1;
                            state_next = S_RD;
                        end
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_WNEW: begin
                wr_en      = 1'b1;
                count_next = count_reg + 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        func_reg   <= func_next;
        word_reg   <= word_next;
        prio_reg   <= prio_next;
        ptr_reg    <= ptr_next;
        status_reg <= status_next;
        dout_reg   <= dout_next;
        found_reg  <= found_next;
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (state_reg == S_RD) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Shadow of the head entry's priority, refreshed on every write to slot zero.
    always_ff @(posedge aclk) begin
        if (wr_en && wr_addr == '0) begin
            head_prio_reg <= wr_data[EW-1:DW];
        end
    end

    assign stat.idle = (state_reg == S_IDLE);
    assign stat.done = done;

    assign rsp.status        = status_reg;
    assign rsp.data_out      = 32'(dout_reg);
    assign rsp.found         = found_reg;
    assign rsp.entry_total   = 5'(count_reg);
    assign rsp.head_priority = (count_reg == '0) ? '0 : head_prio_reg;

    `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(DEPTH), "entry count above depth")
    `SPQ_ASSERT_NOW(a_wr_in_range, wr_en, CW'(wr_addr) <= count_reg, "write beyond filled region")
    `SPQ_ASSERT_NOW(a_done_slot_free, done, out_free, "result finished into a busy output slot")
    `SPQ_ASSERT_NEXT(a_count_step, start && stat.idle, (count_reg == $past(count_reg)) || (count_reg == '0) || (count_reg == $past(count_reg) + 1'b1) || (count_reg == $past(count_reg) - 1'b1), "entry count moved by more than one")

endmodule

// File: rtl/core/stable_priority_queue.sv
// Top level of the stable priority queue: stream ports and output register.
// Depends on spq_pkg and spq_engine.
//
//  channel  | direction | tdata (low bit up)                              | tuser
//  ---------+-----------+-------------------------------------------------+--------
//  s_axis   | in        | item_data[31:0], priority_req[15:0]             | func
//  m_axis   | out       | status, data_out, found, entry_total, head_prio | none
//
// Push moves each entry of lower priority one slot toward the tail; pop shifts
// every stored entry toward the head; contains compares entries until a match.
// The entry memory's single read port serialises the entry visits. Reset clears
// the entry count, not the entry memory; no clearing pass. A result waits in the
// output register while the next item is taken; the engine holds its finished
// result only when that register is still occupied.
module stable_priority_queue #(
    parameter int DEPTH      = spq_pkg::DEPTH_DEF,
    parameter int ITEM_BYTES = spq_pkg::ITEM_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // item_data[31:0], priority_req[47:32]
    input  logic [2:0]  s_axis_tuser,   // func[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // status[1:0], data_out[33:2], found[34],
                                        // entry_total[39:35], head_priority[55:40]
);

    spq_pkg::req_t      req;
    spq_pkg::rsp_t      rsp;
    spq_pkg::eng_stat_t stat;
    logic               start;
    logic               out_free;
    logic               m_valid_reg, m_valid_next;
    logic [55:0]        m_data_reg;

    // Unpack the input item.
    assign req.func         = s_axis_tuser;
    assign req.item_data    = s_axis_tdata[31:0];
    assign req.priority_req = s_axis_tdata[47:32];

    assign s_axis_tready = stat.idle;
    assign start         = s_axis_tvalid && stat.idle;
    assign out_free      = !m_valid_reg || m_axis_tready;

    spq_engine #(
        .DEPTH      (DEPTH),
        .ITEM_BYTES (ITEM_BYTES)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .req      (req),
        .out_free (out_free),
        .stat     (stat),
        .rsp      (rsp)
    );

    // Output register valid flag.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (stat.done) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Output register payload, packed from the lowest field up.
    always_ff @(posedge aclk) begin
        if (stat.done) begin
            m_data_reg <= {rsp.head_priority, rsp.entry_total, rsp.found,
                           rsp.data_out, rsp.status};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// File: verif/spq_result_check.sv
// Result checker for the stable priority queue: follows both stream channels,
// predicts each answer from its own copy of the queue and compares.
// Depends on spq_pkg; instantiated next to the block by stable_priority_queue_tb.
module spq_result_check
    import spq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int ITEM_BYTES = ITEM_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // item_data[31:0], priority_req[47:32]
    input  logic [2:0]  s_axis_tuser,   // func[2:0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,   // status[1:0], data_out[33:2], found[34],
                                        // entry_total[39:35], head_priority[55:40]
    output int          mismatches,
    output int          answers_owed,
    output int          answers_checked,
    output int          full_answers,
    output int          empty_answers
);

    // Only the low ITEM_BYTES bytes of a word are stored and compared.
    localparam logic [31:0] WORD_MASK = (ITEM_BYTES >= 4) ? 32'hFFFF_FFFF :
                                        ((32'd1 << (8 * ITEM_BYTES)) - 32'd1);

    // Shadow copy of the queue, head at index 0.
    logic [31:0]        held_word [DEPTH];
    logic signed [15:0] held_prio [DEPTH];
    int                 held_count;

    // Answers predicted for accepted items, oldest first.
    rsp_t answers_due [$];

    // Applies one request to the shadow queue and works out its answer.
    task automatic apply_request(input logic [2:0] op, input logic [31:0] raw_word,
                                 input logic signed [15:0] prio, output rsp_t ans);
        logic [31:0] word;
        int          pos;
        word = raw_word & WORD_MASK;
        ans  = '0;
        case (op)
            FN_PUSH: begin
                if (held_count >= DEPTH) begin
                    ans.status = STAT_FULL;
                end else begin
                    // New entry goes behind every entry of equal or higher priority.
                    pos = 0;
                    while (pos < held_count && held_prio[pos] >= prio)
                        pos++;
                    for (int i = held_count; i > pos; i--) begin
                        held_word[i] = held_word[i-1];
                        held_prio[i] = held_prio[i-1];
                    end
                    held_word[pos] = word;
                    held_prio[pos] = prio;
                    held_count++;
                end
            end
            FN_POP: begin
                if (held_count == 0) begin
                    ans.status = STAT_EMPTY;
                end else begin
                    ans.data_out = held_word[0];
                    for (int i = 1; i < held_count; i++) begin
                        held_word[i-1] = held_word[i];
                        held_prio[i-1] = held_prio[i];
                    end
                    held_count--;
                end
            end
            FN_PEEK: begin
                if (held_count == 0)
                    ans.status = STAT_EMPTY;
                else
                    ans.data_out = held_word[0];
            end
            FN_FIND: begin
                for (int i = 0; i < held_count; i++) begin
                    if (held_word[i] == word)
                        ans.found = 1'b1;
                end
            end
            FN_CLEAR: begin
                held_count = 0;
            end
            default: begin
                // Unused selectors leave the queue alone.
            end
        endcase
        ans.entry_total   = held_count[4:0];
        ans.head_priority = (held_count != 0) ? held_prio[0] : 16'sd0;
    endtask

    // Prints one field that disagrees and counts it.
    task automatic flag_field(input string name, input longint want_v, input longint got_v);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
        mismatches++;
    endtask

    // Both channels are sampled at the rising edge; inputs settle at the falling edge.
    always @(posedge aclk) begin
        rsp_t want;
        rsp_t got;
        if (!aresetn) begin
            held_count      = 0;
            mismatches      = 0;
            answers_checked = 0;
            full_answers    = 0;
            empty_answers   = 0;
            answers_due.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_request(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[47:32], want);
                answers_due.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.status        = m_axis_tdata[1:0];
                got.data_out      = m_axis_tdata[33:2];
                got.found         = m_axis_tdata[34];
                got.entry_total   = m_axis_tdata[39:35];
                got.head_priority = m_axis_tdata[55:40];
                if (answers_due.size() == 0) begin
                    $display("%0t: result with no item waiting, expected none, got %h",
                             $time, m_axis_tdata);
                    mismatches++;
                end else begin
                    want = answers_due.pop_front();
                    answers_checked++;
                    if (want.status == STAT_FULL)
                        full_answers++;
                    if (want.status == STAT_EMPTY)
                        empty_answers++;
                    if (got.status != want.status)
                        flag_field("status", want.status, got.status);
                    if (got.data_out != want.data_out)
                        flag_field("data_out", want.data_out, got.data_out);
                    if (got.found != want.found)
                        flag_field("found", want.found, got.found);
                    if (got.entry_total != want.entry_total)
                        flag_field("entry_total", want.entry_total, got.entry_total);
                    if (got.head_priority !== want.head_priority)
                        flag_field("head_priority", want.head_priority, got.head_priority);
                end
            end
        end
        answers_owed = answers_due.size();
    end

endmodule

// File: verif/stable_priority_queue_tb.sv
// Testbench top for the stable priority queue: clock, reset, item stimulus
// with random idling on both channels, and the final verdict.
// Depends on spq_pkg, stable_priority_queue and spq_result_check.
module stable_priority_queue_tb;
    import spq_pkg::*;

    localparam int ITEM_TARGET = 1750;

    // Selector values that no operation uses.
    localparam logic [2:0] FN_SPARE_FIRST = 3'd5;
    localparam logic [2:0] FN_SPARE_LAST  = 3'd7;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // item_data[31:0], priority_req[47:32]
    logic [2:0]  s_axis_tuser;   // func[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // status[1:0], data_out[33:2], found[34],
                                 // entry_total[39:35], head_priority[55:40]

    int mismatches;
    int answers_owed;
    int answers_checked;
    int full_answers;
    int empty_answers;

    // When set, neither side inserts idle cycles.
    bit          steady_flow;
    int          items_sent;
    int          op_tally [8];
    logic [31:0] word_pool [8];

    stable_priority_queue dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    spq_result_check result_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .mismatches      (mismatches),
        .answers_owed    (answers_owed),
        .answers_checked (answers_checked),
        .full_answers    (full_answers),
        .empty_answers   (empty_answers)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Offers one item after a random gap and holds it until it is taken.
    task automatic send_item(input logic [2:0] op, input logic [31:0] word,
                             input logic signed [15:0] prio);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tdata  = {prio, word};
        s_axis_tuser  = op;
        s_axis_tvalid = 1'b1;
        do begin
            @(posedge aclk);
        end while (!s_axis_tready);
        @(negedge aclk);
        op_tally[op]++;
        items_sent++;
    endtask

    // Draws one random item; push and pop shares set the fill trend.
    task automatic send_random(input int push_pct, input int pop_pct, input bit tight_prio);
        int                 roll;
        int                 level;
        logic [31:0]        word;
        logic signed [15:0] prio;
        roll  = $urandom_range(0, 99);
        word  = ($urandom_range(0, 3) == 0) ? $urandom : word_pool[$urandom_range(0, 7)];
        level = $urandom_range(0, 6) - 3;
        prio  = tight_prio ? level[15:0] : 16'($urandom);
        if (roll < push_pct)
            send_item(FN_PUSH, word, prio);
        else if (roll < push_pct + pop_pct)
            send_item(FN_POP, $urandom, 16'($urandom));
        else if (roll < push_pct + pop_pct + 10)
            send_item(FN_FIND, word, 16'($urandom));
        else if (roll < push_pct + pop_pct + 12)
            send_item(FN_CLEAR, $urandom, 16'($urandom));
        else if (roll < push_pct + pop_pct + 14)
            send_item(3'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST)), $urandom,
                      16'($urandom));
        else
            send_item(FN_PEEK, $urandom, 16'($urandom));
    endtask

    // Result side: random stall before each result, none while steady_flow is set.
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            stall = steady_flow ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_axis_tready = 1'b1;
            do begin
                @(posedge aclk);
            end while (!m_axis_tvalid);
        end
    end

    // Main stimulus and verdict.
    initial begin
        int base;
        int span;
        int mode;
        bit tight;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FN_PUSH;
        steady_flow   = 1'b0;
        items_sent    = 0;
        foreach (op_tally[i]) op_tally[i] = 0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty-queue answers, priority extremes, ties kept in arrival order.
        send_item(FN_POP, 32'h0, 16'sd0);
        send_item(FN_PEEK, 32'h0, 16'sd0);
        send_item(FN_FIND, 32'h0, 16'sd0);
        send_item(FN_CLEAR, 32'h0, 16'sd0);
        send_item(FN_SPARE_FIRST, 32'hFFFF_FFFF, -16'sd1);
        send_item(FN_PUSH, 32'hFFFF_FFFF, 16'sh7FFF);
        send_item(FN_PUSH, 32'h0000_0000, -16'sh8000);
        send_item(FN_PUSH, 32'hAAAA_5555, 16'sd0);
        send_item(FN_PUSH, 32'h5555_AAAA, 16'sd0);
        send_item(FN_PUSH, 32'h0000_0001, -16'sd1);
        send_item(FN_PEEK, 32'h0, 16'sd0);
        send_item(FN_FIND, 32'h0000_0000, 16'sd0);
        send_item(FN_FIND, 32'h1234_5678, 16'sd0);
        send_item(FN_POP, 32'h0, 16'sd0);
        send_item(FN_POP, 32'h0, 16'sd0);
        send_item(FN_POP, 32'h0, 16'sd0);
        send_item(FN_SPARE_LAST, 32'h0, 16'sd0);
        send_item(FN_CLEAR, 32'h0, 16'sd0);
        send_item(FN_PEEK, 32'h0, 16'sd0);
        // Fill past capacity so pushes come back full.
        for (int i = 0; i < DEPTH_DEF + 2; i++)
            send_item(FN_PUSH, $urandom, 16'($urandom_range(0, 3)));
        send_item(FN_CLEAR, 32'h0, 16'sd0);

        // Random episodes: filling, draining and balanced mixes, some with close priorities.
        base = items_sent;
        while (items_sent - base < ITEM_TARGET) begin
            foreach (word_pool[i]) word_pool[i] = $urandom;
            span        = $urandom_range(20, 60);
            mode        = $urandom_range(0, 2);
            tight       = 1'($urandom_range(0, 1));
            steady_flow = ($urandom_range(0, 3) == 0);
            repeat (span) begin
                case (mode)
                    0:       send_random(70, 8, tight);
                    1:       send_random(15, 60, tight);
                    default: send_random(40, 38, tight);
                endcase
            end
        end

        s_axis_tvalid = 1'b0;
        steady_flow   = 1'b0;
        while (answers_owed != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);

        $display("Items sent: %0d (push %0d, pop %0d, peek %0d, contains %0d, clear %0d).",
                 items_sent, op_tally[FN_PUSH], op_tally[FN_POP], op_tally[FN_PEEK],
                 op_tally[FN_FIND], op_tally[FN_CLEAR]);
        $display("Results compared: %0d, of which %0d full and %0d empty answers.",
                 answers_checked, full_answers, empty_answers);
        if (mismatches == 0 && answers_owed == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
